[rtl/vacc_pkg.sv]
// Package: shared types, constants and helpers of the altitude/climb controller.
package vacc_pkg;

	localparam int unsigned THROTTLE_FULL_SCALE_DEF = 9600;
	localparam int unsigned INTEGRAL_LIMIT_DEF      = 150;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 31;

	typedef enum logic [1:0] {
		ACT_MANUAL    = 2'd0,
		ACT_AUTO_THR  = 2'd1,
		ACT_AUTO_CLB  = 2'd2,
		ACT_AUTO_ALT  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_ALT_GAIN   = 3'd0,
		REG_MAX_CLIMB  = 3'd1,
		REG_CRUISE_THR = 3'd2,
		REG_CLIMB_INC  = 3'd3,
		REG_THR_PGAIN  = 3'd4,
		REG_THR_IGAIN  = 3'd5,
		REG_THR_DGAIN  = 3'd6,
		REG_PITCH_GAIN = 3'd7
	} reg_idx_t;

	// datapath micro-steps
	typedef enum logic [3:0] {
		OP_LOAD     = 4'd0,  // latch inputs, compute altitude error
		OP_ALT_MUL  = 4'd1,  // altitude_gain * alt_err
		OP_CLIMB    = 4'd2,  // climb setpoint, speed error, error difference
		OP_I_MUL    = 4'd3,  // igain * integral
		OP_D_MUL    = 4'd4,  // dgain * derr
		OP_INNER    = 4'd5,  // inner sum
		OP_P_MUL    = 4'd6,  // pgain * inner
		OP_C_MUL    = 4'd7,  // climb_increment * climb
		OP_PITCH    = 4'd8,  // pitch_gain * climb
		OP_FINISH   = 4'd9   // throttle scale and state write
	} op_t;

	typedef struct packed {
		logic go;
		op_t  op;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
	} dp_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction

endpackage

[rtl/vacc_ctrl.sv]
// Controller: sequences the datapath steps for one control tick.
module vacc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_go,
	input  logic [1:0] action,
	output logic busy,
	output logic finish,
	output vacc_pkg::dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_LAST = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;
	vacc_pkg::op_t op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= vacc_pkg::OP_LOAD;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_go) begin
						state_q <= ST_RUN;
						op_q <= (action == vacc_pkg::ACT_AUTO_ALT) ?
							vacc_pkg::OP_ALT_MUL : vacc_pkg::OP_CLIMB;
					end
				end
				ST_RUN: begin
					if (op_q == vacc_pkg::OP_PITCH) begin
						state_q <= ST_LAST;
						op_q <= vacc_pkg::OP_FINISH;
					end else begin
						op_q <= vacc_pkg::op_t'(op_q + 4'd1);
					end
				end
				ST_LAST: state_q <= ST_DONE;
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.go = 1'b0;
		cmd.op = vacc_pkg::OP_LOAD;
		if (state_q == ST_IDLE) begin
			cmd.go = in_go;
		end else if (state_q == ST_RUN || state_q == ST_LAST) begin
			cmd.go = 1'b1;
			cmd.op = op_q;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign finish = (state_q == ST_LAST);

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LAST |=> state_q == ST_DONE) else $error("finish not followed");
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_go && state_q == ST_IDLE |=> state_q == ST_RUN) else $error("start lost");

endmodule

[rtl/vacc_dp.sv]
// Datapath: shared multiplier, loop state and output arithmetic.
module vacc_dp #(
	parameter int unsigned THROTTLE_FULL_SCALE = vacc_pkg::THROTTLE_FULL_SCALE_DEF,
	parameter int unsigned INTEGRAL_LIMIT = vacc_pkg::INTEGRAL_LIMIT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  vacc_pkg::dp_cmd_t cmd,
	input  logic [1:0] action,
	input  logic signed [31:0] altitude_target,
	input  logic signed [31:0] pre_climb,
	input  logic signed [31:0] climb_target,
	input  logic signed [31:0] measured_altitude,
	input  logic signed [31:0] measured_vertical_speed,
	input  logic [13:0] nav_throttle,
	input  logic signed [31:0] nav_pitch_cmd,
	input  logic throttle_enable,
	input  logic [30:0] altitude_gain,
	input  logic [30:0] max_climb_rate,
	input  logic [16:0] cruise_throttle,
	input  logic [30:0] climb_increment,
	input  logic [30:0] throttle_pgain,
	input  logic [30:0] throttle_igain,
	input  logic [30:0] throttle_dgain,
	input  logic [30:0] pitch_from_climb_gain,
	output logic [13:0] throttle_res,
	output logic signed [31:0] pitch_res,
	output logic signed [31:0] climb_res
);

	localparam logic signed [33:0] ILIM = 34'(INTEGRAL_LIMIT) <<< 16;
	localparam logic [13:0] FS14 = 14'(THROTTLE_FULL_SCALE);

	logic [1:0] act_q;
	logic signed [31:0] pre_q, vz_q, npitch_q, climb_q, alterr_q;
	logic [13:0] nthr_q;
	logic en_q;
	logic signed [31:0] integ_q, prev_q, hpitch_q, alterr_state_q;
	logic [13:0] hthr_q;
	logic signed [31:0] err_q, derr_q, imul_q, dmul_q, inner_q, pmul_q, cmul_q;
	logic signed [31:0] mres;

	// shared multiplier: one gain by one operand per step
	logic [30:0] m_gain;
	logic signed [31:0] m_x;
	logic signed [63:0] m_p;
	logic signed [47:0] m_sh;

	always_comb begin
		m_gain = altitude_gain;
		m_x = alterr_q;
		case (cmd.op)
			vacc_pkg::OP_I_MUL: begin m_gain = throttle_igain; m_x = integ_q; end
			vacc_pkg::OP_D_MUL: begin m_gain = throttle_dgain; m_x = derr_q; end
			vacc_pkg::OP_P_MUL: begin m_gain = throttle_pgain; m_x = inner_q; end
			vacc_pkg::OP_C_MUL: begin m_gain = climb_increment; m_x = climb_q; end
			vacc_pkg::OP_PITCH: begin m_gain = pitch_from_climb_gain; m_x = climb_q; end
			default: ;
		endcase
		m_p = $signed({33'd0, m_gain}) * 64'(m_x);
		m_sh = m_p[63:16];  // arithmetic shift = floor
		if (m_sh > 48'sh7FFF_FFFF) mres = 32'sh7FFF_FFFF;
		else if (m_sh < -48'sh8000_0000) mres = 32'sh8000_0000;
		else mres = m_sh[31:0];
	end

	logic signed [33:0] c_sum, m_ext, e_sum, d_sum, i_sum, s_sum, pt_sum, f_sum;
	logic signed [31:0] climb_sel, err_n;
	logic [16:0] f_clamp;
	logic [30:0] f_prod;
	logic [47:0] thr_wide;
	logic [13:0] thr_n;

	always_comb begin
		m_ext = 34'(max_climb_rate);
		c_sum = 34'(mres) + 34'(pre_q);
		if (c_sum > m_ext) climb_sel = m_ext[31:0];
		else if (c_sum < -m_ext) climb_sel = 32'(-m_ext);
		else climb_sel = c_sum[31:0];
		if (act_q != vacc_pkg::ACT_AUTO_ALT) climb_sel = climb_q;
		e_sum = 34'(vz_q) - 34'(climb_sel);
		err_n = vacc_pkg::sat32(e_sum);
		d_sum = 34'(err_n) - 34'(prev_q);
		i_sum = 34'(err_q) + 34'(imul_q) + 34'(dmul_q);
		s_sum = 34'(integ_q) + 34'(err_q);
		pt_sum = 34'(mres) + 34'(npitch_q);
		f_sum = 34'(cruise_throttle) + 34'(cmul_q) - 34'(pmul_q);
		if (f_sum < 0) f_clamp = 17'd0;
		else if (f_sum > 34'sd65536) f_clamp = 17'd65536;
		else f_clamp = f_sum[16:0];
		f_prod = 31'(f_clamp) * 31'(FS14);
		thr_wide = 48'(f_prod) >> 16;
		thr_n = thr_wide[13:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			case (cmd.op)
				vacc_pkg::OP_LOAD: begin
					act_q <= action;
					pre_q <= pre_climb;
					vz_q <= measured_vertical_speed;
					npitch_q <= nav_pitch_cmd;
					climb_q <= climb_target;
					nthr_q <= nav_throttle;
					en_q <= throttle_enable;
					alterr_q <= vacc_pkg::sat32(34'(altitude_target) - 34'(measured_altitude));
				end
				vacc_pkg::OP_ALT_MUL: ;
				vacc_pkg::OP_CLIMB: begin
					climb_q <= climb_sel;
					err_q <= err_n;
					derr_q <= vacc_pkg::sat32(d_sum);
				end
				vacc_pkg::OP_I_MUL: imul_q <= mres;
				vacc_pkg::OP_D_MUL: dmul_q <= mres;
				vacc_pkg::OP_INNER: inner_q <= vacc_pkg::sat32(i_sum);
				vacc_pkg::OP_P_MUL: pmul_q <= mres;
				vacc_pkg::OP_C_MUL: cmul_q <= mres;
				// keep the raw navigation pitch for the pass-through mode
				vacc_pkg::OP_PITCH: if (act_q[1]) npitch_q <= vacc_pkg::sat32(pt_sum);
				default: ;
			endcase
		end
	end

	// CLIMB keeps the multiplier on the altitude product so climb_sel sees it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q <= '0;
			hthr_q <= '0;
			hpitch_q <= '0;
			alterr_state_q <= '0;
		end else if (cmd.go && cmd.op == vacc_pkg::OP_FINISH) begin
			if (act_q == vacc_pkg::ACT_AUTO_ALT) alterr_state_q <= alterr_q;
			if (act_q == vacc_pkg::ACT_AUTO_THR) begin
				hthr_q <= (nthr_q > FS14) ? FS14 : nthr_q;
				hpitch_q <= npitch_q;
			end else if (act_q[1]) begin
				prev_q <= err_q;
				integ_q <= (s_sum > ILIM) ? ILIM[31:0] :
					(s_sum < -ILIM) ? 32'(-ILIM) : s_sum[31:0];
				hpitch_q <= npitch_q;
				hthr_q <= thr_n;
			end
			if (!en_q) hthr_q <= '0;
		end
	end

	assign throttle_res = hthr_q;
	assign pitch_res = hpitch_q;
	assign climb_res = climb_q;

	a_integ: assert property (@(posedge clk) disable iff (!arst_n)
		34'(integ_q) <= ILIM && 34'(integ_q) >= -ILIM) else $error("integrator out of range");
	a_thr: assert property (@(posedge clk) disable iff (!arst_n)
		hthr_q <= FS14) else $error("throttle above full scale");
	a_dis: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go && cmd.op == vacc_pkg::OP_FINISH && !en_q |=> hthr_q == '0)
		else $error("disable not applied");

endmodule

[rtl/vertical_altitude_climb_controller.sv]
// Top level: altitude/climb controller with configuration registers and output stage.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one control tick: the guidance
//   action, altitude and climb targets, measurements, navigation throttle and
//   pitch, and the throttle enable. One transaction is taken when in_valid is
//   high and in_stall is low.
//   Output channel (out_valid/out_stall) returns one transaction per tick:
//   throttle_out, pitch_out and climb_out.
//   Each tick runs through a single shared 31x32 multiplier, one product per
//   step, sequenced by the controller: load, climb, multiply, sum and finish
//   steps, with the altitude product step in auto_alt mode only. One tick is in
//   flight at a time; the next is taken once the result has been moved to the
//   output register, so a new tick can enter while the previous result waits
//   to be taken.
//   Holding out_stall holds out_valid and the payload; a finished tick then
//   waits in the datapath and in_stall stays high.
//   Reset clears the loop state (integrator, last error, held throttle and pitch)
//   and sets the registers to their defaults (max_climb_rate = 1.0). Configuration
//   writes via cfg_we/cfg_index/cfg_data: the user does them while idle (unchecked).
module vertical_altitude_climb_controller #(
	parameter int unsigned THROTTLE_FULL_SCALE = vacc_pkg::THROTTLE_FULL_SCALE_DEF,
	parameter int unsigned INTEGRAL_LIMIT = vacc_pkg::INTEGRAL_LIMIT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [vacc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vacc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] action,
	input  logic signed [31:0] altitude_target,
	input  logic signed [31:0] pre_climb,
	input  logic signed [31:0] climb_target,
	input  logic signed [31:0] measured_altitude,
	input  logic signed [31:0] measured_vertical_speed,
	input  logic [13:0] nav_throttle,
	input  logic signed [31:0] nav_pitch_cmd,
	input  logic throttle_enable,
	output logic out_valid,
	input  logic out_stall,
	output logic [13:0] throttle_out,
	output logic signed [31:0] pitch_out,
	output logic signed [31:0] climb_out
);

	logic [30:0] alt_gain_q, max_climb_q, climb_inc_q, pgain_q, igain_q, dgain_q, pgc_q;
	logic [16:0] cruise_q;

	// register file: every one of the eight index codes selects a register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_gain_q <= '0;
			max_climb_q <= 31'd65536;
			cruise_q <= '0;
			climb_inc_q <= '0;
			pgain_q <= '0;
			igain_q <= '0;
			dgain_q <= '0;
			pgc_q <= '0;
		end else if (cfg_we) begin
			unique case (vacc_pkg::reg_idx_t'(cfg_index))
				vacc_pkg::REG_ALT_GAIN:   alt_gain_q <= cfg_data;
				vacc_pkg::REG_MAX_CLIMB:  max_climb_q <= cfg_data;
				vacc_pkg::REG_CRUISE_THR: cruise_q <= cfg_data[16:0];
				vacc_pkg::REG_CLIMB_INC:  climb_inc_q <= cfg_data;
				vacc_pkg::REG_THR_PGAIN:  pgain_q <= cfg_data;
				vacc_pkg::REG_THR_IGAIN:  igain_q <= cfg_data;
				vacc_pkg::REG_THR_DGAIN:  dgain_q <= cfg_data;
				vacc_pkg::REG_PITCH_GAIN: pgc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic busy, finish, in_go, pend_q;
	vacc_pkg::dp_cmd_t cmd;
	logic [13:0] thr_res;
	logic signed [31:0] pitch_res, climb_res;

	assign in_stall = busy || pend_q;
	assign in_go = in_valid && !in_stall;

	vacc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(in_go), .action(action),
		.busy(busy), .finish(finish), .cmd(cmd)
	);

	vacc_dp #(
		.THROTTLE_FULL_SCALE(THROTTLE_FULL_SCALE), .INTEGRAL_LIMIT(INTEGRAL_LIMIT)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .action(action),
		.altitude_target(altitude_target), .pre_climb(pre_climb),
		.climb_target(climb_target), .measured_altitude(measured_altitude),
		.measured_vertical_speed(measured_vertical_speed), .nav_throttle(nav_throttle),
		.nav_pitch_cmd(nav_pitch_cmd), .throttle_enable(throttle_enable),
		.altitude_gain(alt_gain_q), .max_climb_rate(max_climb_q),
		.cruise_throttle(cruise_q), .climb_increment(climb_inc_q),
		.throttle_pgain(pgain_q), .throttle_igain(igain_q), .throttle_dgain(dgain_q),
		.pitch_from_climb_gain(pgc_q),
		.throttle_res(thr_res), .pitch_res(pitch_res), .climb_res(climb_res)
	);

	// pend_q: a finished tick waits for the output register to free up
	logic load_out;
	assign load_out = pend_q && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (finish) pend_q <= 1'b1;
			else if (load_out) pend_q <= 1'b0;
			if (load_out) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			throttle_out <= thr_res;
			pitch_out <= pitch_res;
			climb_out <= climb_res;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(climb_out))
		else $error("stalled output changed");
	a_nostart: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> in_stall) else $error("transaction taken while result pending");
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> !pend_q) else $error("result overrun");

endmodule
